>>> rtl/ufsf_pkg.sv
// ufsf_pkg: shared widths, codes, state and handshake types for the spanning forest block
// no dependencies; compiled before every other file of the block
package ufsf_pkg;

  // default forest size, handed to the top level parameter
  localparam int MAX_VERTICES_DEF = 1024;

  // field widths
  localparam int VTX_W = 10;
  localparam int WT_W  = 16;
  localparam int WS_W  = 26;
  localparam int CNT_W = 10;
  localparam int STS_W = 2;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-1:0] ADDR_VCOUNT = CFG_AW'(0);
  localparam logic [VTX_W-1:0]  VCOUNT_RST  = VTX_W'(1023);

  // saturation limits
  localparam logic [WS_W-1:0]  WSUM_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_EDGE  = 1'b1
  } ufsf_cmd_code_t;

  typedef enum logic [STS_W-1:0] {
    STAT_ACCEPT  = 2'd0,
    STAT_REJECT  = 2'd1,
    STAT_BAD     = 2'd2,
    STAT_CLEARED = 2'd3
  } ufsf_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_A_WALK,
    ST_A_COMP,
    ST_B_WALK,
    ST_B_COMP,
    ST_HOLD
  } ufsf_state_t;

  // source of the walk pointer for the next cycle (also the read address)
  typedef enum logic [2:0] {
    CSEL_HOLD,
    CSEL_IN_A,
    CSEL_DATA,
    CSEL_A,
    CSEL_B
  } ufsf_csel_t;

  // controller to datapath
  typedef struct packed {
    logic         accept;     // capture the item, rewind sweep index
    ufsf_csel_t   csel;
    logic         root_set;   // root_r <= cur_r
    logic         ra_set;     // ra_r <= root_r
    logic         fill;       // parent[idx] <= idx, idx++
    logic         comp_wr;    // parent[cur] <= root
    logic         link;       // join roots if they differ, update totals
    logic         zero;       // clear totals
    logic         out_load;
    ufsf_status_t out_status;
  } ufsf_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_start;
    logic in_ok;
    logic par_self;
    logic at_root;
    logic fill_more;
    logic clear_last;
    logic roots_eq;
    logic out_free;
  } ufsf_stat_t;

endpackage

>>> rtl/ufsf_if.sv
// ufsf_in_if / ufsf_out_if: valid-ready channels for edge commands and results
// depends on ufsf_pkg for field widths
interface ufsf_in_if;
  import ufsf_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [WT_W-1:0]  edge_weight;
  logic [VTX_W-1:0] vertex_a;
  logic [VTX_W-1:0] vertex_b;

  modport source (output valid, cmd, edge_weight, vertex_a, vertex_b, input ready);
  modport sink   (input valid, cmd, edge_weight, vertex_a, vertex_b, output ready);
endinterface

interface ufsf_out_if;
  import ufsf_pkg::*;

  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [WS_W-1:0]  tree_weight;
  logic [CNT_W-1:0] tree_edges;
  logic             spanning_done;

  modport source (output valid, status, tree_weight, tree_edges, spanning_done, input ready);
  modport sink   (input valid, status, tree_weight, tree_edges, spanning_done, output ready);
endinterface

>>> rtl/ufsf_ram.sv
// ufsf_ram: generic single-write, single-read memory with registered read data
// no package dependency
module ufsf_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ufsf_ctrl.sv
// ufsf_ctrl: sequencer for clearing, start sweeps, root walks, compression and linking
// depends on ufsf_pkg for state, command and status types
module ufsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ufsf_pkg::ufsf_stat_t stat,
  output ufsf_pkg::ufsf_ctl_t  ctl
);
  import ufsf_pkg::*;

  ufsf_state_t  state_r, state_nxt;
  ufsf_status_t pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // pending status while the result slot is occupied
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    in_ready       = 1'b0;
    ctl            = '0;
    ctl.csel       = CSEL_HOLD;
    ctl.out_status = STAT_ACCEPT;

    unique case (state_r)
      ST_CLEAR: begin
        ctl.fill = 1'b1;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.csel = CSEL_IN_A;
        if (in_valid) begin
          ctl.accept = 1'b1;
          if (stat.in_start) begin
            ctl.zero  = 1'b1;
            state_nxt = ST_SWEEP;
          end else if (!stat.in_ok) begin
            if (stat.out_free) begin
              ctl.out_load   = 1'b1;
              ctl.out_status = STAT_BAD;
            end else begin
              pend_nxt  = STAT_BAD;
              state_nxt = ST_HOLD;
            end
          end else begin
            state_nxt = ST_A_WALK;
          end
        end
      end

      ST_SWEEP: begin
        if (stat.fill_more) begin
          ctl.fill = 1'b1;
        end else if (stat.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = STAT_CLEARED;
          state_nxt      = ST_IDLE;
        end else begin
          pend_nxt  = STAT_CLEARED;
          state_nxt = ST_HOLD;
        end
      end

      ST_A_WALK: begin
        if (stat.par_self) begin
          ctl.root_set = 1'b1;
          ctl.csel     = CSEL_A;
          state_nxt    = ST_A_COMP;
        end else begin
          ctl.csel = CSEL_DATA;
        end
      end

      ST_A_COMP: begin
        if (stat.at_root) begin
          ctl.ra_set = 1'b1;
          ctl.csel   = CSEL_B;
          state_nxt  = ST_B_WALK;
        end else begin
          ctl.comp_wr = 1'b1;
          ctl.csel    = CSEL_DATA;
        end
      end

      ST_B_WALK: begin
        if (stat.par_self) begin
          ctl.root_set = 1'b1;
          ctl.csel     = CSEL_B;
          state_nxt    = ST_B_COMP;
        end else begin
          ctl.csel = CSEL_DATA;
        end
      end

      ST_B_COMP: begin
        if (stat.at_root) begin
          ctl.link = 1'b1;
          if (stat.out_free) begin
            ctl.out_load   = 1'b1;
            ctl.out_status = stat.roots_eq ? STAT_REJECT : STAT_ACCEPT;
            state_nxt      = ST_IDLE;
          end else begin
            pend_nxt  = stat.roots_eq ? STAT_REJECT : STAT_ACCEPT;
            state_nxt = ST_HOLD;
          end
        end else begin
          ctl.comp_wr = 1'b1;
          ctl.csel    = CSEL_DATA;
        end
      end

      ST_HOLD: begin
        if (stat.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.out_status = pend_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ufsf_dp.sv
// ufsf_dp: parent table, walk registers, running totals and the result register
// depends on ufsf_pkg and ufsf_ram
module ufsf_dp #(
  parameter int MAX_VERTICES = ufsf_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_cmd,
  input  logic [ufsf_pkg::WT_W-1:0]   in_edge_weight,
  input  logic [ufsf_pkg::VTX_W-1:0]  in_vertex_a,
  input  logic [ufsf_pkg::VTX_W-1:0]  in_vertex_b,
  input  logic [ufsf_pkg::VTX_W-1:0]  vcount,
  input  ufsf_pkg::ufsf_ctl_t         ctl,
  output ufsf_pkg::ufsf_stat_t        stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ufsf_pkg::STS_W-1:0]  out_status,
  output logic [ufsf_pkg::WS_W-1:0]   out_tree_weight,
  output logic [ufsf_pkg::CNT_W-1:0]  out_tree_edges,
  output logic                        out_spanning_done
);
  import ufsf_pkg::*;

  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CW   = AW + 1;
  localparam int SE_W = WS_W + 1;
  localparam int DN_W = CNT_W + 1;

  logic [VTX_W-1:0] a_r, b_r, cur_r, cur_nxt, root_r, ra_r;
  logic [WT_W-1:0]  w_r;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [WS_W-1:0]  wsum_r, wsum_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SE_W-1:0]  sum_ext;
  logic             out_valid_r, out_valid_nxt;
  logic [STS_W-1:0] out_status_r;
  logic [WS_W-1:0]  out_weight_r;
  logic [CNT_W-1:0] out_edges_r;
  logic             out_done_r;
  logic             joined;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VTX_W-1:0] ram_wdata, ram_rdata;

  function automatic logic vtx_ok(input logic [VTX_W-1:0] v, input logic [VTX_W-1:0] n);
    return (v != '0) && (v <= n) && (32'(v) < MAX_VERTICES);
  endfunction

  ufsf_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES)
  ) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // walk pointer; the read address always follows it so data lines up next cycle
  always_comb begin
    case (ctl.csel)
      CSEL_IN_A: cur_nxt = in_vertex_a;
      CSEL_DATA: cur_nxt = ram_rdata;
      CSEL_A:    cur_nxt = a_r;
      CSEL_B:    cur_nxt = b_r;
      default:   cur_nxt = cur_r;
    endcase
  end
  assign ram_raddr = AW'(cur_nxt);

  assign joined = ctl.link && (ra_r != root_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cur_r);
    ram_wdata = root_r;
    if (ctl.fill) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r[AW-1:0];
      ram_wdata = VTX_W'(idx_r);
    end else if (ctl.comp_wr) begin
      ram_we = 1'b1;
    end else if (joined) begin
      ram_we    = 1'b1;
      ram_waddr = AW'(ra_r);
    end
  end

  // totals
  assign sum_ext = {1'b0, wsum_r} + SE_W'(w_r);

  always_comb begin
    wsum_nxt = wsum_r;
    cnt_nxt  = cnt_r;
    if (ctl.zero) begin
      wsum_nxt = '0;
      cnt_nxt  = '0;
    end else if (joined) begin
      wsum_nxt = sum_ext[WS_W] ? WSUM_MAX : sum_ext[WS_W-1:0];
      cnt_nxt  = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (ctl.accept) begin
      idx_nxt = CW'(1);
    end else if (ctl.fill) begin
      idx_nxt = idx_r + CW'(1);
    end
  end

  assign out_valid_nxt = ctl.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      wsum_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      wsum_r      <= wsum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (ctl.accept) begin
      a_r <= in_vertex_a;
      b_r <= in_vertex_b;
      w_r <= in_edge_weight;
    end
    if (ctl.root_set) begin
      root_r <= cur_r;
    end
    if (ctl.ra_set) begin
      ra_r <= root_r;
    end
    if (ctl.out_load) begin
      out_status_r <= ctl.out_status;
      out_weight_r <= wsum_nxt;
      out_edges_r  <= cnt_nxt;
      out_done_r   <= (DN_W'(cnt_nxt) + DN_W'(1)) == DN_W'(vcount);
    end
  end

  assign stat.in_start   = (in_cmd == CMD_START);
  assign stat.in_ok      = (in_cmd == CMD_EDGE) && vtx_ok(in_vertex_a, vcount)
                           && vtx_ok(in_vertex_b, vcount);
  assign stat.par_self   = (ram_rdata == cur_r);
  assign stat.at_root    = (cur_r == root_r);
  assign stat.fill_more  = (32'(idx_r) <= 32'(vcount)) && (32'(idx_r) < MAX_VERTICES);
  assign stat.clear_last = (32'(idx_r) == MAX_VERTICES - 1);
  assign stat.roots_eq   = (ra_r == root_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_tree_weight   = out_weight_r;
  assign out_tree_edges    = out_edges_r;
  assign out_spanning_done = out_done_r;

endmodule

>>> rtl/union_find_spanning_forest_top.sv
// union_find_spanning_forest_top: kruskal edge filter over a union-find forest
// depends on ufsf_pkg, ufsf_if, ufsf_ram, ufsf_ctrl and ufsf_dp
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+---------------------------------------------
//  in_ch    | in  | valid / ready        | cmd, edge_weight, vertex_a, vertex_b
//  out_ch   | out | valid / ready        | status, tree_weight, tree_edges, spanning_done
//  cfg      | in  | psel/penable/pready  | vertex_count at byte address 0
//
// after reset a clearing pass points every parent entry at itself, with in_ch.ready low;
//   configuration writes are taken throughout
// edge: both endpoints are walked along their parent chains; each chain step is one
//   read of the parent table, once to find the root and once to compress the path
// start: one table write per vertex, from 1 up to min(vertex_count, MAX_VERTICES-1)
// bad vertex: answered from idle without a table walk; a result waiting in the output
//   register does not block the next accept, only the hand-off of the following result
module union_find_spanning_forest_top #(
  parameter int MAX_VERTICES = ufsf_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  ufsf_in_if.sink                      in_ch,
  ufsf_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ufsf_pkg::CFG_AW-1:0]  paddr,
  input  logic [ufsf_pkg::CFG_DW-1:0]  pwdata,
  output logic [ufsf_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import ufsf_pkg::*;

  ufsf_ctl_t        ctl;
  ufsf_stat_t       stat;
  logic [VTX_W-1:0] vcount_r, vcount_nxt;
  logic             cfg_wr;

  // configuration register, written in the apb access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_VCOUNT);

  assign vcount_nxt = cfg_wr ? pwdata[VTX_W-1:0] : vcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RST;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  // only the vertex count register reads back; other addresses read zero
  assign prdata = (paddr == ADDR_VCOUNT) ? CFG_DW'(vcount_r) : '0;

  // sequencer: decides each cycle what the datapath does
  ufsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // parent table, walk pointers, totals and the output register
  ufsf_dp #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_cmd            (in_ch.cmd),
    .in_edge_weight    (in_ch.edge_weight),
    .in_vertex_a       (in_ch.vertex_a),
    .in_vertex_b       (in_ch.vertex_b),
    .vcount            (vcount_r),
    .ctl               (ctl),
    .stat              (stat),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_tree_weight   (out_ch.tree_weight),
    .out_tree_edges    (out_ch.tree_edges),
    .out_spanning_done (out_ch.spanning_done)
  );

endmodule

>>> test/testbench.sv
// testbench: self-checking bench for union_find_spanning_forest_top, kruskal edge filter
// depends on rtl/ufsf_pkg.sv, rtl/ufsf_if.sv and the block's rtl; drives edges, checks results
`timescale 1ns / 100ps

module testbench;
  import ufsf_pkg::*;

  localparam int MAXV = MAX_VERTICES_DEF;

  // one edge command as the sender holds it
  typedef struct {
    ufsf_cmd_code_t   cmd;
    logic [WT_W-1:0]  weight;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
  } edge_item_t;

  // one result item as the block should hand it out
  typedef struct {
    ufsf_status_t     status;
    logic [WS_W-1:0]  sum;
    logic [CNT_W-1:0] count;
    logic             done;
  } tree_result_t;

  logic clk = 1'b0;
  logic rst_n;

  // configuration port, apb style
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  ufsf_in_if  in_ch();
  ufsf_out_if out_ch();

  union_find_spanning_forest_top uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // forest model: own copy of the parent table, totals and vertex count
  // ---------------------------------------------------------------------------
  logic [VTX_W-1:0] forest [0:MAXV-1];
  logic [WS_W-1:0]  tree_sum;
  logic [CNT_W-1:0] tree_count;
  logic [VTX_W-1:0] vcount_cfg;

  edge_item_t   edge_stream[$];   // items waiting for the driver
  tree_result_t awaited[$];       // results owed by the block, oldest first
  int           outstanding;      // items queued whose result has not been checked yet
  int           errors;

  int  send_idle_pct;
  int  recv_idle_pct;
  logic rx_blocked;
  event rx_stall_go;

  // root of v; every vertex on the walked chain is pointed straight at the root
  function automatic logic [VTX_W-1:0] leader_of(input logic [VTX_W-1:0] v);
    logic [VTX_W-1:0] r;
    logic [VTX_W-1:0] nxt;
    int               steps;
    r = v;
    steps = 0;
    while (forest[r] != r && steps < MAXV) begin
      r = forest[r];
      steps++;
    end
    steps = 0;
    while (v != r && steps < MAXV) begin
      nxt = forest[v];
      forest[v] = r;
      v = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic bit in_graph(input logic [VTX_W-1:0] v);
    return v != '0 && v <= vcount_cfg;
  endfunction

  // applies one accepted item to the forest model and returns what the block must answer
  function automatic tree_result_t kruskal_step(input edge_item_t it);
    tree_result_t     r;
    logic [VTX_W-1:0] ra;
    logic [VTX_W-1:0] rb;
    logic [WS_W:0]    wide_sum;
    int               i;
    if (it.cmd == CMD_START) begin
      // only vertices in use become roots again, the rest keep their links
      for (i = 1; i <= int'(vcount_cfg) && i < MAXV; i++) forest[i] = VTX_W'(i);
      tree_sum = '0;
      tree_count = '0;
      r.status = STAT_CLEARED;
    end else if (!in_graph(it.va) || !in_graph(it.vb)) begin
      r.status = STAT_BAD;
    end else begin
      ra = leader_of(it.va);
      rb = leader_of(it.vb);
      if (ra == rb) begin
        // also covers self loops
        r.status = STAT_REJECT;
      end else begin
        forest[ra] = rb;
        wide_sum = {1'b0, tree_sum} + it.weight;
        tree_sum = (wide_sum > WSUM_MAX) ? WSUM_MAX : wide_sum[WS_W-1:0];
        if (tree_count != CNT_MAX) tree_count = tree_count + 1'b1;
        r.status = STAT_ACCEPT;
      end
    end
    r.sum = tree_sum;
    r.count = tree_count;
    r.done = (int'(tree_count) + 1 == int'(vcount_cfg));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued items, hands each accepted one to the forest model
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_edges
    edge_item_t on_wire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) awaited = {awaited, kruskal_step(on_wire)};
      // valid only moves once the current item is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (edge_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_wire = edge_stream.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.cmd         <= on_wire.cmd;
          in_ch.edge_weight <= on_wire.weight;
          in_ch.vertex_a    <= on_wire.va;
          in_ch.vertex_b    <= on_wire.vb;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a forced hold-off while rx_blocked is up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !rx_blocked && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // long hold-off on the result side, counted here so the sender keeps pushing
  always begin
    @(rx_stall_go);
    rx_blocked <= 1'b1;
    repeat (400) @(posedge clk);
    rx_blocked <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // monitor: every result item against the oldest awaited one, field by field
  // ---------------------------------------------------------------------------
  task automatic report_field(input string field, input int unsigned exp_v, act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    errors++;
  endtask

  always @(posedge clk) begin : check_results
    tree_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited, expected none, actual status %0d",
                 $time, out_ch.status);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (out_ch.status !== want.status)
          report_field("status", want.status, out_ch.status);
        if (out_ch.tree_weight !== want.sum)
          report_field("tree_weight", want.sum, out_ch.tree_weight);
        if (out_ch.tree_edges !== want.count)
          report_field("tree_edges", want.count, out_ch.tree_edges);
        if (out_ch.spanning_done !== want.done)
          report_field("spanning_done", want.done, out_ch.spanning_done);
        outstanding--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_item(input ufsf_cmd_code_t cmd, input logic [WT_W-1:0] w,
                           input logic [VTX_W-1:0] a, input logic [VTX_W-1:0] b);
    edge_item_t it;
    it.cmd = cmd;
    it.weight = w;
    it.va = a;
    it.vb = b;
    edge_stream = {edge_stream, it};
    outstanding++;
  endtask

  // returns once every queued item has been answered and checked, then lets the block settle
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // apb write of the vertex count: setup cycle, then access cycle
  task automatic write_vertex_count(input logic [VTX_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_VCOUNT;
    pwdata  <= CFG_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    vcount_cfg = val;
  endtask

  // a graph: optional start, then edges in mostly ascending weight order;
  // some unsorted weights, self loops, out-of-range endpoints and restarts mixed in
  task automatic queue_graph(input int n, input bit with_start);
    logic [WT_W-1:0]  w;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic [VTX_W-1:0] bad;
    int               pick;
    int               step;
    int               restart_pct;
    int               i;
    w = WT_W'($urandom_range(0, 40000));
    restart_pct = (vcount_cfg <= 16) ? 8 : 2;
    if (with_start)
      push_item(CMD_START, WT_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < restart_pct) begin
        push_item(CMD_START, WT_W'($urandom), VTX_W'($urandom), VTX_W'($urandom));
        w = WT_W'($urandom_range(0, 40000));
      end else begin
        if (pick < 12) begin
          w = WT_W'($urandom);
        end else begin
          step = $urandom_range(0, 300);
          w = (int'(w) + step > 65535) ? '1 : WT_W'(int'(w) + step);
        end
        a = (vcount_cfg == '0) ? VTX_W'($urandom) : VTX_W'($urandom_range(1, vcount_cfg));
        b = (vcount_cfg == '0) ? VTX_W'($urandom) : VTX_W'($urandom_range(1, vcount_cfg));
        if (pick < 17) begin
          b = a;
        end else if (pick < 27) begin
          case ($urandom_range(0, 2))
            0:       bad = '0;
            1:       bad = (vcount_cfg == '1) ? '0 : VTX_W'($urandom_range(vcount_cfg + 1, 1023));
            default: bad = VTX_W'($urandom);
          endcase
          if ($urandom_range(0, 1) != 0) a = bad;
          else b = bad;
        end
        push_item(CMD_EDGE, w, a, b);
      end
    end
  endtask

  task automatic run_phase(input logic [VTX_W-1:0] vc, input int n, input bit with_start);
    wait_drained();
    write_vertex_count(vc);
    queue_graph(n, with_start);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    // all inputs known from time zero
    rst_n   = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_START;
    in_ch.edge_weight = '0;
    in_ch.vertex_a    = '0;
    in_ch.vertex_b    = '0;
    out_ch.ready      = 1'b0;
    rx_blocked        = 1'b0;
    send_idle_pct     = 16;
    recv_idle_pct     = 76;
    outstanding       = 0;
    errors            = 0;

    // model state after reset: every vertex its own root, reset vertex count
    for (i = 0; i < MAXV; i++) forest[i] = VTX_W'(i);
    tree_sum   = '0;
    tree_count = '0;
    vcount_cfg = VCOUNT_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, full vertex range; the block is still clearing its table here
    write_vertex_count(10'd1023);
    push_item(CMD_EDGE, 16'd0, 10'd1, 10'd2);            // edge straight out of reset
    push_item(CMD_START, 16'd0, 10'd0, 10'd0);
    push_item(CMD_EDGE, 16'hFFFF, 10'd1023, 10'd1);      // top vertex, top weight
    push_item(CMD_EDGE, 16'hFFFF, 10'd1, 10'd1023);      // same component
    push_item(CMD_EDGE, 16'h5555, 10'h155, 10'h2AA);     // alternating bit patterns
    push_item(CMD_EDGE, 16'hAAAA, 10'h2AA, 10'd1);
    push_item(CMD_EDGE, 16'hAAAB, 10'd9, 10'd9);         // self loop
    push_item(CMD_EDGE, 16'hAAAC, 10'd0, 10'd5);         // vertex zero on either side
    push_item(CMD_EDGE, 16'hAAAC, 10'd5, 10'd0);
    push_item(CMD_EDGE, 16'hAAAD, 10'h155, 10'd1023);    // joined through three earlier edges
    push_item(CMD_START, 16'hFFFF, 10'd1023, 10'd1023);  // start ignores its payload
    push_item(CMD_EDGE, 16'd10, 10'd1023, 10'd1023);

    // zero vertex count: every endpoint is bad, spanning_done stays low
    wait_drained();
    write_vertex_count(10'd0);
    push_item(CMD_START, 16'd0, 10'd0, 10'd0);
    push_item(CMD_EDGE, 16'd1, 10'd1, 10'd1);
    push_item(CMD_EDGE, 16'd2, 10'd1023, 10'd1023);

    // single vertex: the empty tree already spans it
    wait_drained();
    write_vertex_count(10'd1);
    push_item(CMD_START, 16'd0, 10'd0, 10'd0);
    push_item(CMD_EDGE, 16'd3, 10'd1, 10'd1);
    push_item(CMD_EDGE, 16'd4, 10'd1, 10'd2);
    push_item(CMD_EDGE, 16'd5, 10'd2, 10'd1);

    // count raised without a start: vertices 2 and 3 keep their old links
    wait_drained();
    write_vertex_count(10'd3);
    push_item(CMD_EDGE, 16'd6, 10'd1, 10'd2);
    push_item(CMD_EDGE, 16'd7, 10'd2, 10'd3);
    push_item(CMD_EDGE, 16'd8, 10'd3, 10'd1);
    push_item(CMD_EDGE, 16'd9, 10'd1, 10'd4);

    // random part, first regime: sender idles a little, receiver a lot
    run_phase(10'd4, 60, 1'b1);
    run_phase(10'd16, 120, 1'b1);
    run_phase(10'd1023, 100, 1'b1);

    // second regime: the other way round
    wait_drained();
    send_idle_pct <= 76;
    recv_idle_pct <= 16;
    // smaller count with no start, links left over from the full graph stay in place
    run_phase(10'd8, 60, 1'b0);
    run_phase(10'd37, 75, 1'b1);
    // sender pauses until every result is in, then the same graph goes on
    wait_drained();
    queue_graph(75, 1'b0);
    run_phase(10'd2, 40, 1'b1);

    // third regime: no idling on either side
    wait_drained();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_phase(10'd100, 200, 1'b1);
    // receiver holds off while items keep coming, so the input side backs up
    -> rx_stall_go;
    run_phase(VTX_W'($urandom_range(3, 60)), 150, 1'b1);
    run_phase(10'd1, 20, 1'b1);
    run_phase(10'd12, 100, 1'b1);
    run_phase(10'd1023, 80, 1'b1);

    // everything answered, then a quiet wait for anything stray
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && awaited.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
